@@ sv/twr_pkg.sv @@
package twr_pkg;

    // field and datapath widths
    localparam int STAMP_W = 40;
    localparam int PEER_W  = 3;
    localparam int KIND_W  = 3;
    localparam int DIFF_W  = 32;
    localparam int DEN_W   = 34;
    localparam int PROD_W  = 64;
    localparam int AD_W    = 20;
    localparam int MM_W    = 24;
    localparam int SCL_W   = 56;
    localparam int DVD_W   = 88;
    localparam int DIVS_W  = 50;
    localparam int Q_W     = 33;
    localparam int DIST_W  = 32;
    localparam int CNT_W   = $clog2(DVD_W);

    // event kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_POLL_TX = 3'd0,
        KIND_ANS_TX  = 3'd1,
        KIND_FIN_TX  = 3'd2,
        KIND_POLL_RX = 3'd3,
        KIND_ANS_RX  = 3'd4,
        KIND_FIN_RX  = 3'd5,
        KIND_REPORT  = 3'd6
    } t_kind;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_ANTENNA_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MM_PER_TICK   = 1'b1;
    localparam logic [MM_W-1:0] MM_PER_TICK_RESET = 24'd307479;

    // result codes
    localparam logic RES_DISTANCE   = 1'b0;
    localparam logic RES_REPORT     = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_ZERO_DEN = 1'b1;

    // timestamp store indexes
    localparam int ST_POLL_TX = 0;
    localparam int ST_ANS_TX  = 1;
    localparam int ST_FIN_TX  = 2;
    localparam int ST_POLL_RX = 3;
    localparam int ST_ANS_RX  = 4;
    localparam int ST_FIN_RX  = 5;
    localparam int ST_COUNT   = 6;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        t_kind                kind;
        logic [PEER_W-1:0]    peer;
        logic [STAMP_W-1:0]   stamp;
        logic [STAMP_W-1:0]   rpr;
        logic [STAMP_W-1:0]   rat;
        logic [STAMP_W-1:0]   rfr;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef struct packed {
        logic                     rtype;
        logic [PEER_W-1:0]        peer;
        logic signed [DIST_W-1:0] dist_mm;
        logic                     status;
        logic [STAMP_W-1:0]       rpr;
        logic [STAMP_W-1:0]       rat;
        logic [STAMP_W-1:0]       rfr;
    } t_result;

endpackage

@@ sv/twr_front.sv @@
module twr_front #(
    parameter int PEER_COUNT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [twr_pkg::KIND_W-1:0]          i_kind,
    input  logic [twr_pkg::PEER_W-1:0]          i_peer,
    input  logic [twr_pkg::STAMP_W-1:0]         i_stamp,
    input  logic [twr_pkg::STAMP_W-1:0]         i_rpr,
    input  logic [twr_pkg::STAMP_W-1:0]         i_rat,
    input  logic [twr_pkg::STAMP_W-1:0]         i_rfr,
    input  logic [twr_pkg::AD_W-1:0]            i_antenna_delay,
    output twr_pkg::t_qhead                     o_head,
    input  logic                                i_pop
);

    logic [twr_pkg::STAMP_W-1:0] w_half;
    logic                        w_kind_ok;
    logic                        w_peer_ok;
    logic                        w_push;
    twr_pkg::t_item              w_item;

    twr_pkg::t_item              r_q [twr_pkg::Q_DEPTH];
    logic [twr_pkg::Q_PTR_W-1:0] r_wp;
    logic [twr_pkg::Q_PTR_W-1:0] r_rp;
    logic [twr_pkg::Q_CNT_W-1:0] r_cnt;

    // classify the beat and apply half the antenna delay
    always_comb begin
        w_half    = twr_pkg::STAMP_W'(i_antenna_delay >> 1);
        w_kind_ok = (i_kind <= twr_pkg::KIND_W'(twr_pkg::KIND_REPORT));
        w_peer_ok = ({6'b0, i_peer} < 9'(PEER_COUNT));
        w_item.kind = twr_pkg::t_kind'(i_kind);
        w_item.peer = i_peer;
        w_item.rpr  = i_rpr;
        w_item.rat  = i_rat;
        w_item.rfr  = i_rfr;
        case (i_kind) inside
            twr_pkg::KIND_POLL_TX, twr_pkg::KIND_ANS_TX, twr_pkg::KIND_FIN_TX: begin
                w_item.stamp = i_stamp + w_half;
            end
            twr_pkg::KIND_POLL_RX, twr_pkg::KIND_ANS_RX, twr_pkg::KIND_FIN_RX: begin
                w_item.stamp = i_stamp - w_half;
            end
            default: begin
                w_item.stamp = i_stamp;
            end
        endcase
    end

    assign o_ready = (r_cnt != twr_pkg::Q_CNT_W'(twr_pkg::Q_DEPTH));
    assign w_push  = i_valid && o_ready && w_kind_ok && w_peer_ok;

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + twr_pkg::Q_CNT_W'(w_push) - twr_pkg::Q_CNT_W'(i_pop);
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

endmodule

@@ sv/twr_back.sv @@
module twr_back #(
    parameter int PEER_COUNT = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  twr_pkg::t_qhead             i_head,
    output logic                        o_pop,
    input  logic [twr_pkg::MM_W-1:0]    i_mm_per_tick,
    output twr_pkg::t_result            o_res,
    output logic                        o_res_valid,
    input  logic                        i_res_ready
);

    localparam int PIDX_W = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
    localparam logic [twr_pkg::Q_W-1:0] Q_MAX = 33'h1_0000_0000;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_EXEC  = 10'b00_0000_0010,
        S_MUL_A = 10'b00_0000_0100,
        S_MUL_B = 10'b00_0000_1000,
        S_MAG   = 10'b00_0001_0000,
        S_SC_LO = 10'b00_0010_0000,
        S_SC_HI = 10'b00_0100_0000,
        S_SUM   = 10'b00_1000_0000,
        S_DIV   = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } t_state;

    t_state                          r_state, n_state;
    twr_pkg::t_item                  r_item;
    logic [PIDX_W-1:0]               w_waddr, w_raddr;
    logic [twr_pkg::ST_COUNT-1:0]    w_we;
    logic [twr_pkg::STAMP_W-1:0]     w_wd [twr_pkg::ST_COUNT];
    logic [twr_pkg::STAMP_W-1:0]     w_rd [twr_pkg::ST_COUNT];

    logic [twr_pkg::DIFF_W-1:0]      r_r1, r_q1, r_r2, r_q2;
    logic [twr_pkg::DEN_W-1:0]       r_den;
    logic [twr_pkg::PROD_W-1:0]      r_pa, r_pb, r_mag;
    logic                            r_neg, r_zero;
    logic [twr_pkg::SCL_W-1:0]       r_t0, r_t1;
    logic [twr_pkg::DVD_W-1:0]       r_dvd;
    logic [twr_pkg::DIVS_W-1:0]      r_rem;
    logic [twr_pkg::Q_W-1:0]         r_q;
    logic                            r_sat;
    logic [twr_pkg::CNT_W-1:0]       r_cnt;

    logic [twr_pkg::DIFF_W-1:0]      w_mul_a, w_mul_b;
    logic [twr_pkg::PROD_W-1:0]      w_prod;
    logic [twr_pkg::DIVS_W-1:0]      w_dv;
    logic [twr_pkg::DIVS_W:0]        w_rs;
    logic                            w_ge;
    logic [twr_pkg::Q_W:0]           w_qs;
    logic                            w_rnd;
    logic [twr_pkg::Q_W:0]           w_qr;
    logic [twr_pkg::Q_W:0]           w_qm;
    logic [twr_pkg::DIST_W-1:0]      w_dist;
    logic                            w_out_free;
    logic                            w_load;
    twr_pkg::t_result                w_res;
    twr_pkg::t_result                r_res;
    logic                            r_res_valid;

    assign o_pop   = (r_state == S_IDLE) && i_head.valid;
    assign w_waddr = PIDX_W'(r_item.peer);
    assign w_raddr = PIDX_W'(i_head.item.peer);

    // write enables and data of the six stamp stores
    always_comb begin
        logic is_rep;
        is_rep = (r_item.kind == twr_pkg::KIND_REPORT);
        w_we = '0;
        for (int k = 0; k < twr_pkg::ST_COUNT; k++) begin
            w_wd[k] = r_item.stamp;
        end
        if (is_rep) begin
            w_wd[twr_pkg::ST_POLL_RX] = r_item.rpr;
            w_wd[twr_pkg::ST_ANS_TX]  = r_item.rat;
            w_wd[twr_pkg::ST_FIN_RX]  = r_item.rfr;
        end
        if (r_state == S_EXEC) begin
            unique case (r_item.kind)
                twr_pkg::KIND_POLL_TX: w_we[twr_pkg::ST_POLL_TX] = 1'b1;
                twr_pkg::KIND_ANS_TX:  w_we[twr_pkg::ST_ANS_TX]  = 1'b1;
                twr_pkg::KIND_FIN_TX:  w_we[twr_pkg::ST_FIN_TX]  = 1'b1;
                twr_pkg::KIND_POLL_RX: w_we[twr_pkg::ST_POLL_RX] = 1'b1;
                twr_pkg::KIND_ANS_RX:  w_we[twr_pkg::ST_ANS_RX]  = 1'b1;
                twr_pkg::KIND_FIN_RX:  w_we[twr_pkg::ST_FIN_RX]  = 1'b1;
                twr_pkg::KIND_REPORT: begin
                    w_we[twr_pkg::ST_POLL_RX] = 1'b1;
                    w_we[twr_pkg::ST_ANS_TX]  = 1'b1;
                    w_we[twr_pkg::ST_FIN_RX]  = 1'b1;
                end
                default: w_we = '0;
            endcase
        end
    end

    // stamp stores, one memory each, entries read as zero until written
    for (genvar g = 0; g < twr_pkg::ST_COUNT; g++) begin : g_store
        logic [twr_pkg::STAMP_W-1:0] r_mem [PEER_COUNT];
        logic [PEER_COUNT-1:0]       r_vld;
        logic [twr_pkg::STAMP_W-1:0] r_rdata;
        logic                        r_rvld;

        always_ff @(posedge i_clk) begin
            if (w_we[g]) begin
                r_mem[w_waddr] <= w_wd[g];
            end
            if (o_pop) begin
                r_rdata <= r_mem[w_raddr];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld  <= '0;
                r_rvld <= 1'b0;
            end else begin
                if (w_we[g]) begin
                    r_vld[w_waddr] <= 1'b1;
                end
                if (o_pop) begin
                    r_rvld <= r_vld[w_raddr];
                end
            end
        end

        assign w_rd[g] = r_rvld ? r_rdata : '0;
    end

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_MUL_A: begin
                w_mul_a = r_r1;
                w_mul_b = r_r2;
            end
            S_MUL_B: begin
                w_mul_a = r_q1;
                w_mul_b = r_q2;
            end
            S_SC_LO: begin
                w_mul_a = r_mag[31:0];
                w_mul_b = {8'b0, i_mm_per_tick};
            end
            S_SC_HI: begin
                w_mul_a = r_mag[63:32];
                w_mul_b = {8'b0, i_mm_per_tick};
            end
            default: begin
                w_mul_a = r_r1;
                w_mul_b = r_r2;
            end
        endcase
        w_prod = twr_pkg::PROD_W'(w_mul_a) * twr_pkg::PROD_W'(w_mul_b);
    end

    // restoring divider step and final rounding
    always_comb begin
        w_dv  = {r_den, 16'b0};
        w_rs  = {r_rem, r_dvd[twr_pkg::DVD_W-1]};
        w_ge  = (w_rs >= {1'b0, w_dv});
        w_qs  = {r_q, w_ge};
        w_rnd = !r_sat && ({r_rem, 1'b0} >= {1'b0, w_dv});
        w_qr  = {1'b0, r_q} + (twr_pkg::Q_W + 1)'(w_rnd);
        if (!r_neg) begin
            w_qm   = (w_qr > 34'h0_7FFF_FFFF) ? 34'h0_7FFF_FFFF : w_qr;
            w_dist = w_qm[31:0];
        end else begin
            w_qm   = (w_qr > 34'h0_8000_0000) ? 34'h0_8000_0000 : w_qr;
            w_dist = 32'd0 - w_qm[31:0];
        end
    end

    assign w_out_free = !r_res_valid || i_res_ready;

    // result word
    always_comb begin
        w_res.peer = r_item.peer;
        if (r_state == S_EXEC) begin
            w_res.rtype   = twr_pkg::RES_REPORT;
            w_res.dist_mm = '0;
            w_res.status  = twr_pkg::STATUS_OK;
            w_res.rpr     = w_rd[twr_pkg::ST_POLL_RX];
            w_res.rat     = w_rd[twr_pkg::ST_ANS_TX];
            w_res.rfr     = r_item.stamp;
        end else begin
            w_res.rtype   = twr_pkg::RES_DISTANCE;
            w_res.dist_mm = r_zero ? '0 : w_dist;
            w_res.status  = r_zero ? twr_pkg::STATUS_ZERO_DEN : twr_pkg::STATUS_OK;
            w_res.rpr     = '0;
            w_res.rat     = '0;
            w_res.rfr     = '0;
        end
        w_load = w_out_free &&
                 (((r_state == S_EXEC) && (r_item.kind == twr_pkg::KIND_FIN_RX)) ||
                  (r_state == S_FIN));
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_head.valid) n_state = S_EXEC;
            S_EXEC: begin
                if (r_item.kind == twr_pkg::KIND_REPORT) begin
                    n_state = S_MUL_A;
                end else if (r_item.kind != twr_pkg::KIND_FIN_RX || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL_A: n_state = S_MUL_B;
            S_MUL_B: n_state = S_MAG;
            S_MAG:   n_state = (r_den == '0) ? S_FIN : S_SC_LO;
            S_SC_LO: n_state = S_SC_HI;
            S_SC_HI: n_state = S_SUM;
            S_SUM:   n_state = S_DIV;
            S_DIV:   if (r_cnt == '0) n_state = S_FIN;
            S_FIN:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head.item;
        end
        unique case (r_state)
            S_EXEC: begin
                r_r1  <= w_rd[twr_pkg::ST_ANS_RX][31:0] - w_rd[twr_pkg::ST_POLL_TX][31:0];
                r_q1  <= r_item.rat[31:0] - r_item.rpr[31:0];
                r_r2  <= r_item.rfr[31:0] - r_item.rat[31:0];
                r_q2  <= w_rd[twr_pkg::ST_FIN_TX][31:0] - w_rd[twr_pkg::ST_ANS_RX][31:0];
            end
            S_MUL_A: begin
                r_pa  <= w_prod;
                // denominator from the wrapped 32-bit intervals
                r_den <= twr_pkg::DEN_W'(r_r1) + twr_pkg::DEN_W'(r_q1)
                       + twr_pkg::DEN_W'(r_r2) + twr_pkg::DEN_W'(r_q2);
            end
            S_MUL_B: r_pb <= w_prod;
            S_MAG: begin
                r_neg  <= (r_pa < r_pb);
                r_mag  <= (r_pa < r_pb) ? (r_pb - r_pa) : (r_pa - r_pb);
                r_zero <= (r_den == '0);
            end
            S_SC_LO: r_t0 <= twr_pkg::SCL_W'(w_prod);
            S_SC_HI: r_t1 <= twr_pkg::SCL_W'(w_prod);
            S_SUM: begin
                r_dvd <= twr_pkg::DVD_W'(r_t0) + {r_t1, 32'b0};
                r_rem <= '0;
                r_q   <= '0;
                r_sat <= 1'b0;
                r_cnt <= twr_pkg::CNT_W'(twr_pkg::DVD_W - 1);
            end
            S_DIV: begin
                r_rem <= w_ge ? twr_pkg::DIVS_W'(w_rs - {1'b0, w_dv})
                              : twr_pkg::DIVS_W'(w_rs);
                r_dvd <= r_dvd << 1;
                if (w_qs > {1'b0, Q_MAX}) begin
                    r_q   <= Q_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_q <= twr_pkg::Q_W'(w_qs);
                end
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    // checks
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_q <= Q_MAX))
        else $error("quotient above saturation bound");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < w_dv))
        else $error("remainder not below divisor");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_ready) |=> $stable(r_res))
        else $error("result changed while stalled");

    a_dist_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && (r_res.rtype == twr_pkg::RES_DISTANCE)) |->
        ((r_res.rpr == '0) && (r_res.rat == '0) && (r_res.rfr == '0)))
        else $error("distance result carries report stamps");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && (r_res.status == twr_pkg::STATUS_ZERO_DEN)) |->
        (r_res.dist_mm == '0))
        else $error("zero denominator with non-zero distance");

endmodule

@@ sv/twr_timestamp_ranging_engine_unit.sv @@
// sequencing: a stamp event passes the back end's idle and execute states; a
//   final-received also gives its report beat there, waiting while the result is
//   stalled; a report passes multiply and magnitude, then, for a non-zero
//   denominator, scale, sum and the 88-step one-bit-per-cycle restoring divider,
//   then final; a two-entry queue lets the input side run ahead of the sequencer
// reset: synchronous active low; clears stamp valid bits, queue and result valid
module twr_timestamp_ranging_engine_unit #(
    parameter int PEER_COUNT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // peer, stamp, remote_poll_rx, remote_answer_tx, remote_final_rx, zero pad
    input  logic [167:0]                        s_axis_tdata,
    // kind
    input  logic [twr_pkg::KIND_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // result_peer, distance_mm, status, report_poll_rx, report_answer_tx,
    // report_final_rx, zero pad
    output logic [159:0]                        m_axis_tdata,
    // result_type
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [twr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [twr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [twr_pkg::AD_W-1:0] r_antenna_delay;
    logic [twr_pkg::MM_W-1:0] r_mm_per_tick;
    twr_pkg::t_qhead          w_head;
    logic                     w_pop;
    twr_pkg::t_result         w_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_antenna_delay <= '0;
            r_mm_per_tick   <= twr_pkg::MM_PER_TICK_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                twr_pkg::CFG_ANTENNA_DELAY: r_antenna_delay <= i_cfg_data[19:0];
                twr_pkg::CFG_MM_PER_TICK:   r_mm_per_tick   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    twr_front #(.PEER_COUNT(PEER_COUNT)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_kind          (s_axis_tuser),
        .i_peer          (s_axis_tdata[2:0]),
        .i_stamp         (s_axis_tdata[42:3]),
        .i_rpr           (s_axis_tdata[82:43]),
        .i_rat           (s_axis_tdata[122:83]),
        .i_rfr           (s_axis_tdata[162:123]),
        .i_antenna_delay (r_antenna_delay),
        .o_head          (w_head),
        .i_pop           (w_pop)
    );

    twr_back #(.PEER_COUNT(PEER_COUNT)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_mm_per_tick (r_mm_per_tick),
        .o_res         (w_res),
        .o_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready)
    );

    // pack result beat
    assign m_axis_tuser = w_res.rtype;
    assign m_axis_tdata = {4'b0, w_res.rfr, w_res.rat, w_res.rpr, w_res.status,
                           w_res.dist_mm, w_res.peer};

endmodule
